// File: rtl/post_pkg.sv
// shared constants and types for the point-on-segment test
`timescale 1ns / 1ps

package post_pkg;

    localparam int TOL_W     = 23;
    localparam int TOL2_W    = 2 * TOL_W;
    localparam int LIM_W     = 32;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 32;
    localparam int REGION_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEGEN_LIMIT = 1'd1;

    localparam logic [TOL2_W-1:0] TOL2_RESET = 46'd16;
    localparam logic [LIM_W-1:0]  LIM_RESET  = 32'd1;

    typedef enum logic [REGION_W-1:0] {
        REGION_INTERIOR = 2'd0,
        REGION_START    = 2'd1,
        REGION_END      = 2'd2,
        REGION_DEGEN    = 2'd3
    } t_region;

endpackage

// File: rtl/post_if.sv
// query and result channel interfaces
`timescale 1ns / 1ps

interface post_in_if #(
    parameter int COORD_BITS = 24
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] point_z;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] start_z;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic signed [COORD_BITS-1:0] end_z;

    modport source (
        output valid, point_x, point_y, point_z, start_x, start_y, start_z,
               end_x, end_y, end_z,
        input  ready
    );
    modport sink (
        input  valid, point_x, point_y, point_z, start_x, start_y, start_z,
               end_x, end_y, end_z,
        output ready
    );
endinterface

interface post_out_if import post_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                on_segment;
    logic [REGION_W-1:0] region;

    modport source (output valid, on_segment, region, input ready);
    modport sink (input valid, on_segment, region, output ready);
endinterface

// File: rtl/point_on_segment_test.sv
// pipelined point-to-segment distance test
//
//  channel   | dir | handshake    | word
//  ----------+-----+--------------+-----------------------------------------
//  i_pt      | in  | valid/ready  | point, segment start, segment end (xyz)
//  o_res     | out | valid/ready  | on_segment flag, clamp region
//  i_cfg_*   | in  | write enable | tolerance (idx 0), degenerate limit (1)
//
// one word per cycle while o_res is not stalled, through seven register
// stages; the depth is set by the multiplier chain for the squared cross
// product compared against tol^2 * |d|^2, each wide product split into
// halves
// reset (synchronous, active low) clears the stage valid bits and loads the
// register defaults
// a result not taken holds the whole pipeline; i_pt.ready follows from that
`timescale 1ns / 1ps

module point_on_segment_test import post_pkg::*; #(
    parameter int COORD_BITS = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    post_in_if.sink               i_pt,
    post_out_if.source            o_res
);

    localparam int CB  = COORD_BITS;
    localparam int D   = CB + 1;          // signed difference
    localparam int PW  = 2 * D;           // signed product
    localparam int SQ  = 2 * CB + 2;      // sum of three squares
    localparam int DT  = 2 * CB + 3;      // signed dot product
    localparam int CW  = 2 * CB + 2;      // signed cross component
    localparam int CM  = 2 * CB + 1;      // cross component magnitude
    localparam int CH  = CB + 1;          // low half of cross magnitude
    localparam int LL  = CB + 1;          // low half of segment length
    localparam int TP  = TOL_W + LL;      // tol^2 * length partial product
    localparam int QW  = 4 * CB + 4;      // squared cross norm
    localparam int TLW = TOL2_W + SQ;     // tol^2 * length
    localparam int MW  = (QW > TLW) ? QW : TLW;
    localparam int LW  = (SQ > LIM_W) ? SQ : LIM_W;
    localparam int VW  = (SQ > TOL2_W) ? SQ : TOL2_W;

    // configuration
    logic [TOL2_W-1:0] r_tol2;
    logic [LIM_W-1:0]  r_lim;
    logic [TOL_W-1:0]  w_cfg_tol;

    assign w_cfg_tol = i_cfg_wdata[TOL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol2 <= TOL2_RESET;
            r_lim  <= LIM_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TOLERANCE: begin
                    r_tol2 <= TOL2_W'(w_cfg_tol) * TOL2_W'(w_cfg_tol);
                end
                CFG_DEGEN_LIMIT: begin
                    r_lim <= i_cfg_wdata[LIM_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // stall control
    logic r_vld1, r_vld2, r_vld3, r_vld4, r_vld5, r_vld6, r_vld7;
    logic w_adv;

    assign w_adv       = !r_vld7 || o_res.ready;
    assign i_pt.ready  = w_adv;
    assign o_res.valid = r_vld7;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
            r_vld5 <= 1'b0;
            r_vld6 <= 1'b0;
            r_vld7 <= 1'b0;
        end else if (w_adv) begin
            r_vld1 <= i_pt.valid;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
            r_vld4 <= r_vld3;
            r_vld5 <= r_vld4;
            r_vld6 <= r_vld5;
            r_vld7 <= r_vld6;
        end
    end

    // stage 1: differences d = e - s, v = p - s, w = p - e
    logic signed [CB-1:0] w_p [3];
    logic signed [CB-1:0] w_s [3];
    logic signed [CB-1:0] w_e [3];
    logic signed [D-1:0]  n_d1 [3];
    logic signed [D-1:0]  n_v1 [3];
    logic signed [D-1:0]  n_w1 [3];
    logic signed [D-1:0]  r_d1 [3];
    logic signed [D-1:0]  r_v1 [3];
    logic signed [D-1:0]  r_w1 [3];

    assign w_p[0] = i_pt.point_x;
    assign w_p[1] = i_pt.point_y;
    assign w_p[2] = i_pt.point_z;
    assign w_s[0] = i_pt.start_x;
    assign w_s[1] = i_pt.start_y;
    assign w_s[2] = i_pt.start_z;
    assign w_e[0] = i_pt.end_x;
    assign w_e[1] = i_pt.end_y;
    assign w_e[2] = i_pt.end_z;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_d1[k] = D'(w_e[k]) - D'(w_s[k]);
            n_v1[k] = D'(w_p[k]) - D'(w_s[k]);
            n_w1[k] = D'(w_p[k]) - D'(w_e[k]);
        end
    end

    // stage 2: per-axis products and cross product terms
    logic signed [PW-1:0]   n_pdd [3];
    logic signed [PW-1:0]   n_pvv [3];
    logic signed [PW-1:0]   n_pww [3];
    logic signed [PW-1:0]   n_vd2 [3];
    logic signed [PW-1:0]   n_xa2 [3];
    logic signed [PW-1:0]   n_xb2 [3];
    logic [2*CB-1:0]        r_dd2 [3];
    logic [2*CB-1:0]        r_vv2 [3];
    logic [2*CB-1:0]        r_ww2 [3];
    logic signed [PW-1:0]   r_vd2 [3];
    logic signed [PW-1:0]   r_xa2 [3];
    logic signed [PW-1:0]   r_xb2 [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_pdd[k] = PW'(r_d1[k]) * PW'(r_d1[k]);
            n_pvv[k] = PW'(r_v1[k]) * PW'(r_v1[k]);
            n_pww[k] = PW'(r_w1[k]) * PW'(r_w1[k]);
            n_vd2[k] = PW'(r_v1[k]) * PW'(r_d1[k]);
            // (v x d)[k] = v[k+1] d[k+2] - v[k+2] d[k+1]
            n_xa2[k] = PW'(r_v1[(k + 1) % 3]) * PW'(r_d1[(k + 2) % 3]);
            n_xb2[k] = PW'(r_v1[(k + 2) % 3]) * PW'(r_d1[(k + 1) % 3]);
        end
    end

    // stage 3: sums
    logic [SQ-1:0]        n_len3, n_vsq3, n_wsq3;
    logic signed [DT-1:0] n_dot3;
    logic signed [CW-1:0] n_c3 [3];
    logic [SQ-1:0]        r_len3, r_vsq3, r_wsq3;
    logic signed [DT-1:0] r_dot3;
    logic signed [CW-1:0] r_c3 [3];

    always_comb begin
        n_len3 = SQ'(r_dd2[0]) + SQ'(r_dd2[1]) + SQ'(r_dd2[2]);
        n_vsq3 = SQ'(r_vv2[0]) + SQ'(r_vv2[1]) + SQ'(r_vv2[2]);
        n_wsq3 = SQ'(r_ww2[0]) + SQ'(r_ww2[1]) + SQ'(r_ww2[2]);
        n_dot3 = DT'(r_vd2[0]) + DT'(r_vd2[1]) + DT'(r_vd2[2]);
        for (int k = 0; k < 3; k++) begin
            n_c3[k] = CW'(r_xa2[k]) - CW'(r_xb2[k]);
        end
    end

    // stage 4: region, clamped-end hit, cross magnitudes, tol^2 * len partials
    logic signed [CW-1:0] n_cabs [3];
    logic [CM-1:0]        n_cm4 [3];
    logic [TP-1:0]        n_tp4 [4];
    logic                 w_deg, w_dneg, w_dgt, w_vlt, w_wlt;
    t_region              n_reg4;
    logic                 n_hs4;
    logic [CM-1:0]        r_cm4 [3];
    logic [TP-1:0]        r_tp4 [4];
    t_region              r_reg4;
    logic                 r_hs4;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_cabs[k] = r_c3[k][CW-1] ? -r_c3[k] : r_c3[k];
            n_cm4[k]  = n_cabs[k][CM-1:0];
        end
        // tol^2 and length each split into a low and a high half
        n_tp4[0] = TP'(r_tol2[TOL_W-1:0])      * TP'(r_len3[LL-1:0]);
        n_tp4[1] = TP'(r_tol2[TOL_W-1:0])      * TP'(r_len3[SQ-1:LL]);
        n_tp4[2] = TP'(r_tol2[TOL2_W-1:TOL_W]) * TP'(r_len3[LL-1:0]);
        n_tp4[3] = TP'(r_tol2[TOL2_W-1:TOL_W]) * TP'(r_len3[SQ-1:LL]);
    end

    always_comb begin
        w_deg  = (r_len3 == '0) || (LW'(r_len3) < LW'(r_lim));
        w_dneg = r_dot3[DT-1];
        // dot is known non-negative where this is used
        w_dgt  = r_dot3[SQ-1:0] > r_len3;
        w_vlt  = VW'(r_vsq3) < VW'(r_tol2);
        w_wlt  = VW'(r_wsq3) < VW'(r_tol2);
        if (w_deg) begin
            n_reg4 = REGION_DEGEN;
            n_hs4  = w_vlt;
        end else if (w_dneg) begin
            n_reg4 = REGION_START;
            n_hs4  = w_vlt;
        end else if (w_dgt) begin
            n_reg4 = REGION_END;
            n_hs4  = w_wlt;
        end else begin
            n_reg4 = REGION_INTERIOR;
            n_hs4  = 1'b0;
        end
    end

    // stage 5: cross magnitude half products, tol^2 * len assembled
    logic [2*CB-1:0] n_hh5 [3];
    logic [2*CB:0]   n_hl5 [3];
    logic [2*CB+1:0] n_ll5 [3];
    logic [MW-1:0]   n_tl5;
    logic [2*CB-1:0] r_hh5 [3];
    logic [2*CB:0]   r_hl5 [3];
    logic [2*CB+1:0] r_ll5 [3];
    logic [MW-1:0]   r_tl5;
    t_region         r_reg5;
    logic            r_hs5;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_hh5[k] = (2 * CB)'(r_cm4[k][CM-1:CH]) * (2 * CB)'(r_cm4[k][CM-1:CH]);
            n_hl5[k] = (2 * CB + 1)'(r_cm4[k][CM-1:CH]) * (2 * CB + 1)'(r_cm4[k][CH-1:0]);
            n_ll5[k] = (2 * CB + 2)'(r_cm4[k][CH-1:0]) * (2 * CB + 2)'(r_cm4[k][CH-1:0]);
        end
        n_tl5 = MW'(r_tp4[0]) + (MW'(r_tp4[1]) << LL) + (MW'(r_tp4[2]) << TOL_W)
              + (MW'(r_tp4[3]) << (TOL_W + LL));
    end

    // stage 6: per-component squares of the cross product
    logic [MW-1:0] n_cs6 [3];
    logic [MW-1:0] r_cs6 [3];
    logic [MW-1:0] r_tl6;
    t_region       r_reg6;
    logic          r_hs6;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_cs6[k] = MW'(r_ll5[k]) + (MW'(r_hl5[k]) << (CH + 1))
                     + (MW'(r_hh5[k]) << (2 * CH));
        end
    end

    // stage 7: |v x d|^2 < tol^2 * |d|^2 for the interior case
    logic [MW-1:0] n_cn7;
    logic          n_hit7;
    logic          r_hit7;
    t_region       r_reg7;

    always_comb begin
        n_cn7  = r_cs6[0] + r_cs6[1] + r_cs6[2];
        n_hit7 = (r_reg6 == REGION_INTERIOR) ? (n_cn7 < r_tl6) : r_hs6;
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < 3; k++) begin
                r_d1[k]  <= n_d1[k];
                r_v1[k]  <= n_v1[k];
                r_w1[k]  <= n_w1[k];
                r_dd2[k] <= n_pdd[k][2*CB-1:0];
                r_vv2[k] <= n_pvv[k][2*CB-1:0];
                r_ww2[k] <= n_pww[k][2*CB-1:0];
                r_vd2[k] <= n_vd2[k];
                r_xa2[k] <= n_xa2[k];
                r_xb2[k] <= n_xb2[k];
                r_c3[k]  <= n_c3[k];
                r_cm4[k] <= n_cm4[k];
                r_hh5[k] <= n_hh5[k];
                r_hl5[k] <= n_hl5[k];
                r_ll5[k] <= n_ll5[k];
                r_cs6[k] <= n_cs6[k];
            end
            for (int j = 0; j < 4; j++) begin
                r_tp4[j] <= n_tp4[j];
            end
            r_len3 <= n_len3;
            r_vsq3 <= n_vsq3;
            r_wsq3 <= n_wsq3;
            r_dot3 <= n_dot3;
            r_reg4 <= n_reg4;
            r_hs4  <= n_hs4;
            r_tl5  <= n_tl5;
            r_reg5 <= r_reg4;
            r_hs5  <= r_hs4;
            r_tl6  <= r_tl5;
            r_reg6 <= r_reg5;
            r_hs6  <= r_hs5;
            r_hit7 <= n_hit7;
            r_reg7 <= r_reg6;
        end
    end

    assign o_res.on_segment = r_hit7;
    assign o_res.region     = r_reg7;

endmodule

// File: bench/tb_point_on_segment_test.sv
// self-checking bench for the point-on-segment distance test
`timescale 1ns / 1ps

module tb_point_on_segment_test;
    import post_pkg::*;

    localparam int COORD_W = 24;
    localparam int TIMEOUT_CYCLES = 200000;
    localparam int DRAIN_SLACK = 10;
    localparam int PRINT_CAP = 50;
    localparam int C_MAX = 8388607;
    localparam int C_MIN = -8388608;

    typedef struct {
        logic signed [COORD_W-1:0] point[3];
        logic signed [COORD_W-1:0] seg_start[3];
        logic signed [COORD_W-1:0] seg_end[3];
    } t_query;

    typedef struct {
        logic    on_segment;
        t_region region;
    } t_verdict;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    post_in_if #(.COORD_BITS(COORD_W)) pt_ch ();
    post_out_if res_ch ();

    point_on_segment_test #(.COORD_BITS(COORD_W)) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pt        (pt_ch),
        .o_res       (res_ch)
    );

    // register copies used by the predictor
    logic [TOL_W-1:0] tol_mirror   = 23'd4;
    logic [LIM_W-1:0] limit_mirror = 32'd1;

    t_verdict pending_verdicts[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int noise_base     = 3;
    int cycle_count    = 0;
    int error_count    = 0;
    int checked_count  = 0;
    int sent_count     = 0;
    int hit_count      = 0;
    int config_count   = 0;
    int region_tally[4] = '{0, 0, 0, 0};

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= TIMEOUT_CYCLES) begin
            $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
                     pending_verdicts.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result side back-pressure
    initial begin
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= PRINT_CAP)
            $display("MISMATCH cycle %0d: %s", cycle_count, msg);
    endtask

    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_verdicts.size() == 0) begin
                report_mismatch("result word with nothing outstanding");
            end else begin
                want = pending_verdicts.pop_front();
                checked_count++;
                if (res_ch.on_segment !== want.on_segment)
                    report_mismatch($sformatf("word %0d on_segment %b, want %b (%s)",
                                              checked_count, res_ch.on_segment,
                                              want.on_segment, want.region.name()));
                if (res_ch.region !== want.region)
                    report_mismatch($sformatf("word %0d region %0d, want %s",
                                              checked_count, res_ch.region,
                                              want.region.name()));
            end
        end
    end

    // exact integer distance test on raw coordinate units
    function automatic t_verdict predict_verdict(input t_query q);
        longint d[3], v[3], w[3];
        longint seg_len, v_sq, w_sq, dot, tol_sq;
        logic [127:0] big_len, big_vsq, big_dot, big_tol;
        t_verdict r;
        seg_len = 0;
        v_sq = 0;
        w_sq = 0;
        dot = 0;
        for (int i = 0; i < 3; i++) begin
            d[i] = longint'(q.seg_end[i]) - longint'(q.seg_start[i]);
            v[i] = longint'(q.point[i]) - longint'(q.seg_start[i]);
            w[i] = longint'(q.point[i]) - longint'(q.seg_end[i]);
            seg_len += d[i] * d[i];
            v_sq += v[i] * v[i];
            w_sq += w[i] * w[i];
            dot += v[i] * d[i];
        end
        tol_sq = longint'(tol_mirror) * longint'(tol_mirror);
        if (seg_len == 0 || seg_len < longint'(limit_mirror)) begin
            r.region = REGION_DEGEN;
            r.on_segment = (v_sq < tol_sq);
        end else if (dot < 0) begin
            r.region = REGION_START;
            r.on_segment = (v_sq < tol_sq);
        end else if (dot > seg_len) begin
            r.region = REGION_END;
            r.on_segment = (w_sq < tol_sq);
        end else begin
            big_len = 128'(seg_len);
            big_vsq = 128'(v_sq);
            big_dot = 128'(dot);
            big_tol = 128'(tol_sq);
            r.region = REGION_INTERIOR;
            r.on_segment = (big_vsq * big_len < big_tol * big_len + big_dot * big_dot);
        end
        return r;
    endfunction

    task automatic send_query(input t_query q);
        t_verdict r;
        while ($urandom_range(99) < send_idle_pct) begin
            pt_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        pt_ch.valid   <= 1'b1;
        pt_ch.point_x <= q.point[0];
        pt_ch.point_y <= q.point[1];
        pt_ch.point_z <= q.point[2];
        pt_ch.start_x <= q.seg_start[0];
        pt_ch.start_y <= q.seg_start[1];
        pt_ch.start_z <= q.seg_start[2];
        pt_ch.end_x   <= q.seg_end[0];
        pt_ch.end_y   <= q.seg_end[1];
        pt_ch.end_z   <= q.seg_end[2];
        do @(posedge i_clk); while (!pt_ch.ready);
        r = predict_verdict(q);
        pending_verdicts.push_back(r);
        sent_count++;
        region_tally[r.region]++;
        if (r.on_segment)
            hit_count++;
    endtask

    task automatic drain_results();
        pt_ch.valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_SLACK) @(posedge i_clk);
    endtask

    task automatic apply_config(input logic [TOL_W-1:0] tol, input logic [LIM_W-1:0] lim);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_TOLERANCE;
        i_cfg_wdata <= CFG_DATA_W'(tol);
        @(posedge i_clk);
        tol_mirror = tol;
        i_cfg_idx   <= CFG_DEGEN_LIMIT;
        i_cfg_wdata <= CFG_DATA_W'(lim);
        @(posedge i_clk);
        limit_mirror = lim;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        noise_base = $clog2(int'(tol) + 1);
        config_count++;
    endtask

    function automatic t_query make_query(input int px, input int py, input int pz,
                                          input int sx, input int sy, input int sz,
                                          input int ex, input int ey, input int ez);
        t_query q;
        q.point     = '{px[COORD_W-1:0], py[COORD_W-1:0], pz[COORD_W-1:0]};
        q.seg_start = '{sx[COORD_W-1:0], sy[COORD_W-1:0], sz[COORD_W-1:0]};
        q.seg_end   = '{ex[COORD_W-1:0], ey[COORD_W-1:0], ez[COORD_W-1:0]};
        return q;
    endfunction

    // base plus a signed offset of the given width, wrapped to the coordinate width
    function automatic logic signed [COORD_W-1:0] jitter(input logic signed [31:0] base,
                                                        input int bits);
        logic signed [31:0] offset;
        offset = (bits <= 0) ? 32'sd0 : ($signed($urandom) >>> (32 - bits));
        return COORD_W'(base + offset);
    endfunction

    // mostly points placed along short segments near the tolerance, some pure noise
    function automatic t_query random_query();
        t_query q;
        int seg_bits, noise_bits, frac;
        logic signed [31:0] span;
        seg_bits = ($urandom_range(3) == 0) ? $urandom_range(0, 25) : $urandom_range(0, 14);
        noise_bits = noise_base + $urandom_range(0, 2) - 1;
        if (noise_bits < 0)
            noise_bits = 0;
        for (int i = 0; i < 3; i++) begin
            q.seg_start[i] = COORD_W'($urandom);
            q.seg_end[i]   = jitter(32'(q.seg_start[i]), seg_bits);
            q.point[i]     = COORD_W'($urandom);
        end
        if ($urandom_range(99) >= 15) begin
            frac = $urandom_range(0, 24) - 4;
            for (int i = 0; i < 3; i++) begin
                span = 32'(q.seg_end[i]) - 32'(q.seg_start[i]);
                q.point[i] = jitter(32'(q.seg_start[i]) + (span * frac) / 16, noise_bits);
            end
        end
        return q;
    endfunction

    task automatic test_reset_defaults();
        // zero-length segment, point at and around the start
        send_query(make_query(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_query(make_query(4, 0, 0, 0, 0, 0, 0, 0, 0));
        send_query(make_query(0, 0, -3, 0, 0, 0, 0, 0, 0));
        // full-range segment, projection lands exactly on an end
        send_query(make_query(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX));
        send_query(make_query(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN));
        send_query(make_query(100, -200, 300, 100, -200, 300, 1100, -200, 300));
        // beyond the start and beyond the end
        send_query(make_query(50, 0, 0, 100, 0, 0, 1100, 0, 0));
        send_query(make_query(97, 0, 0, 100, 0, 0, 1100, 0, 0));
        send_query(make_query(1103, 0, 0, 100, 0, 0, 1100, 0, 0));
        send_query(make_query(C_MAX, C_MIN, C_MAX, 100, 0, 0, 1100, 0, 0));
        // interior just inside and exactly at the tolerance, then a full-range interior query
        send_query(make_query(600, 3, 0, 100, 0, 0, 1100, 0, 0));
        send_query(make_query(600, 0, 4, 100, 0, 0, 1100, 0, 0));
        send_query(make_query(C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MIN, C_MIN));
        drain_results();
    endtask

    task automatic test_zero_tolerance();
        apply_config('0, 32'd1);
        send_query(make_query(7, 7, 7, 7, 7, 7, 7, 7, 7));
        send_query(make_query(600, 0, 0, 100, 0, 0, 1100, 0, 0));
        send_query(make_query(100, 0, 0, 100, 0, 0, 1100, 0, 0));
        drain_results();
    endtask

    task automatic test_limit_extremes();
        // zero limit still treats a zero-length segment as a point
        apply_config('1, '0);
        send_query(make_query(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN));
        send_query(make_query(1000, -1000, 0, 0, 0, 0, 0, 0, 0));
        drain_results();
        // widest limit: squared length just below and just above it
        apply_config(23'd4, '1);
        send_query(make_query(65535, 0, 0, 0, 0, 0, 65535, 0, 0));
        send_query(make_query(1, 0, 0, 0, 0, 0, 65535, 0, 0));
        send_query(make_query(32768, 2, 0, 0, 0, 0, 65536, 0, 0));
        drain_results();
    endtask

    task automatic pick_random_config();
        logic [TOL_W-1:0] tol;
        logic [LIM_W-1:0] lim;
        case ($urandom_range(5))
            0: tol = '0;
            1: tol = '1;
            default: tol = TOL_W'($urandom >> (32 - $urandom_range(1, TOL_W)));
        endcase
        case ($urandom_range(5))
            0: lim = '0;
            1: lim = '1;
            2: lim = 32'd1;
            default: lim = $urandom >> $urandom_range(0, 31);
        endcase
        apply_config(tol, lim);
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int n_items);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < n_items; n++) begin
            // sender holds off until everything is back, then retunes the registers
            if (n % 100 == 0) begin
                drain_results();
                pick_random_config();
            end
            send_query(random_query());
        end
        drain_results();
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= '0;
        i_cfg_wdata   <= '0;
        pt_ch.valid   <= 1'b0;
        pt_ch.point_x <= '0;
        pt_ch.point_y <= '0;
        pt_ch.point_z <= '0;
        pt_ch.start_x <= '0;
        pt_ch.start_y <= '0;
        pt_ch.start_z <= '0;
        pt_ch.end_x   <= '0;
        pt_ch.end_y   <= '0;
        pt_ch.end_z   <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_zero_tolerance();
        test_limit_extremes();
        test_random_traffic(0, 0, 400);
        test_random_traffic(56, 0, 400);
        test_random_traffic(0, 56, 400);
        test_random_traffic(23, 23, 400);

        $display("checked %0d of %0d queries over %0d register settings, %0d hits",
                 checked_count, sent_count, config_count, hit_count);
        $display("regions: interior %0d, start %0d, end %0d, degenerate %0d; %0d mismatches",
                 region_tally[REGION_INTERIOR], region_tally[REGION_START],
                 region_tally[REGION_END], region_tally[REGION_DEGEN], error_count);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/post_pkg.sv
rtl/post_if.sv
rtl/point_on_segment_test.sv
bench/tb_point_on_segment_test.sv
